>>> hw/rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Used by the rounding unit and the top level; depends on nothing else.
package ffha_pkg;

  // Stream field widths.
  localparam int unsigned REQ_W       = 16;
  localparam int unsigned REL_W       = 10;
  localparam int unsigned PAY_W       = 10;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  // Byte arithmetic width; covers heap offsets, block ends and rounded requests.
  localparam int unsigned BYTE_W = 18;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_BADREL = 2'd2
  } status_t;

endpackage

>>> hw/rtl/first_fit_heap_allocator.sv
// First-fit heap allocator with split on allocate and neighbor merge on release.
// An allocate rounds its size in RND and NEED, walks the block headers in CHK, writes the split
// tail in SPLIT if any and queues its result in RESP; a release walks in CHK, merges in MERGE
// unless flagged and queues its result in RESP. The walk reads one block header per cycle, at most
// HEAP/HEADER of them. One item at a time: in_tready rises with out_tvalid, and RESP holds while
// an earlier result waits on out_tready. Reset (rst_n low, synchronous) clears control; the cycle
// after it writes the initial free block into entry zero while in_tready stays low.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES   = 1024,
  parameter int unsigned ALIGN_BYTES  = 8,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Request stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] request_size, [25:16] release_address
  input  logic [0:0]             in_tuser,   // [0] mode: 0 allocate, 1 release
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] payload_address
  output logic [STATUS_W-1:0]    out_tuser   // [1:0] status
);

  // Block starts are always multiples of the largest power of two that divides both
  // the alignment and the header size, so the block RAM is indexed in that granule.
  localparam int unsigned AH    = ALIGN_BYTES | HEADER_BYTES;
  localparam int unsigned GRAN  = AH & (~AH + 1);
  localparam int unsigned GSH   = $clog2(GRAN);
  localparam int unsigned DEPTH = (HEAP_BYTES + GRAN - 1) / GRAN;
  localparam int unsigned IW    = $clog2(DEPTH);
  // Each entry holds the header of the block starting there: free flag and payload size.
  localparam int unsigned SZW   = $clog2(HEAP_BYTES);
  localparam int unsigned EW    = SZW + 1;

  localparam logic [BYTE_W-1:0] HDR  = BYTE_W'(HEADER_BYTES);
  localparam logic [BYTE_W-1:0] ALN  = BYTE_W'(ALIGN_BYTES);
  localparam logic [BYTE_W-1:0] HEAP = BYTE_W'(HEAP_BYTES);
  localparam logic [SZW-1:0]    INIT_SIZE = SZW'(HEAP_BYTES - HEADER_BYTES);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RND   = 8'b0000_0100,
    S_NEED  = 8'b0000_1000,
    S_CHK   = 8'b0001_0000,
    S_SPLIT = 8'b0010_0000,
    S_MERGE = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  function automatic logic [IW-1:0] idx_of(input logic [BYTE_W-1:0] b);
    idx_of = b[GSH +: IW];
  endfunction

  // Control registers.
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Item and walk registers (no reset needed).
  logic              mode_r, mode_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [REL_W-1:0]  rel_r, rel_nxt;
  logic [BYTE_W-1:0] cur_r, cur_nxt;
  logic [BYTE_W-1:0] prev_start_r, prev_start_nxt;
  logic [SZW-1:0]    prev_size_r, prev_size_nxt;
  logic              prev_free_r, prev_free_nxt;
  logic              has_prev_r, has_prev_nxt;
  logic [BYTE_W-1:0] hit_start_r, hit_start_nxt;
  logic [SZW-1:0]    hit_size_r, hit_size_nxt;
  logic              has_succ_r, has_succ_nxt;
  logic [BYTE_W-1:0] split_start_r, split_start_nxt;
  logic [SZW-1:0]    split_size_r, split_size_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [PAY_W-1:0]  res_addr_r, res_addr_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [PAY_W-1:0]  out_addr_r, out_addr_nxt;

  // Block RAM port signals.
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  // Datapath on the header just read.
  logic [BYTE_W-1:0] need;
  logic [SZW-1:0]    rd_size;
  logic              rd_free;
  logic [BYTE_W-1:0] rd_size_b, hdr_addr, blk_end, rel_ext, succ_add, merged, prev_merged;
  logic              is_last, fits, can_split, is_hit, past_rel, in_xfer;

  ffha_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The rounded size is registered in q_r and then need_r during states RND and NEED, ready in CHK.
  ffha_round #(
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_round (
    .clk  (clk),
    .req  (req_r),
    .need (need)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - PAY_W){1'b0}}, out_addr_r};
  assign out_tuser  = out_status_r;

  assign rd_size   = ram_rdata[SZW-1:0];
  assign rd_free   = ram_rdata[SZW];
  assign rd_size_b = BYTE_W'(rd_size);
  assign hdr_addr  = cur_r + HDR;
  assign blk_end   = hdr_addr + rd_size_b;
  // Blocks tile the heap exactly, so the last block ends at the heap end.
  assign is_last   = (blk_end >= HEAP);
  assign fits      = rd_free && (rd_size_b >= need);
  assign can_split = (rd_size_b >= need + HDR + ALN);
  assign rel_ext   = BYTE_W'(rel_r);
  assign is_hit    = !rd_free && (hdr_addr == rel_ext);
  // The chain is address ordered, so once a payload start passes the address it can't match.
  assign past_rel  = (hdr_addr > rel_ext);
  // In MERGE the read data is the successor's header.
  assign succ_add  = (has_succ_r && rd_free) ? (rd_size_b + HDR) : '0;
  assign merged    = BYTE_W'(hit_size_r) + succ_add;
  assign prev_merged = BYTE_W'(prev_size_r) + merged + HDR;

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    mode_nxt        = mode_r;
    req_nxt         = req_r;
    rel_nxt         = rel_r;
    cur_nxt         = cur_r;
    prev_start_nxt  = prev_start_r;
    prev_size_nxt   = prev_size_r;
    prev_free_nxt   = prev_free_r;
    has_prev_nxt    = has_prev_r;
    hit_start_nxt   = hit_start_r;
    hit_size_nxt    = hit_size_r;
    has_succ_nxt    = has_succ_r;
    split_start_nxt = split_start_r;
    split_size_nxt  = split_size_r;
    res_status_nxt  = res_status_r;
    res_addr_nxt    = res_addr_r;
    out_status_nxt  = out_status_r;
    out_addr_nxt    = out_addr_r;
    ram_we          = 1'b0;
    ram_waddr       = idx_of(cur_r);
    ram_wdata       = {1'b1, rd_size};
    ram_raddr       = idx_of(cur_r);

    // The result register is freed by a transfer and can be refilled in the same cycle.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        // The whole heap starts as one free block.
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b1, INIT_SIZE};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        ram_raddr = '0;
        if (in_xfer) begin
          mode_nxt     = in_tuser[0];
          req_nxt      = in_tdata[REQ_W-1:0];
          rel_nxt      = in_tdata[REQ_W +: REL_W];
          cur_nxt      = '0;
          has_prev_nxt = 1'b0;
          state_nxt    = in_tuser[0] ? S_CHK : S_RND;
        end
      end
      S_RND: begin
        state_nxt = S_NEED;
      end
      S_NEED: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!mode_r) begin
          if (fits) begin
            ram_we         = 1'b1;
            res_status_nxt = ST_OK;
            res_addr_nxt   = hdr_addr[PAY_W-1:0];
            if (can_split) begin
              ram_wdata       = {1'b0, need[SZW-1:0]};
              split_start_nxt = hdr_addr + need;
              split_size_nxt  = SZW'(rd_size_b - need - HDR);
              state_nxt       = S_SPLIT;
            end else begin
              ram_wdata = {1'b0, rd_size};
              state_nxt = S_RESP;
            end
          end else if (is_last) begin
            res_status_nxt = ST_NOFIT;
            res_addr_nxt   = '0;
            state_nxt      = S_RESP;
          end else begin
            ram_raddr      = idx_of(blk_end);
            cur_nxt        = blk_end;
            prev_start_nxt = cur_r;
            prev_size_nxt  = rd_size;
            prev_free_nxt  = rd_free;
            has_prev_nxt   = 1'b1;
          end
        end else begin
          if (is_hit) begin
            // Fetch the successor header for the merge.
            ram_raddr     = idx_of(blk_end);
            hit_start_nxt = cur_r;
            hit_size_nxt  = rd_size;
            has_succ_nxt  = !is_last;
            state_nxt     = S_MERGE;
          end else if (is_last || past_rel) begin
            res_status_nxt = ST_BADREL;
            res_addr_nxt   = '0;
            state_nxt      = S_RESP;
          end else begin
            ram_raddr      = idx_of(blk_end);
            cur_nxt        = blk_end;
            prev_start_nxt = cur_r;
            prev_size_nxt  = rd_size;
            prev_free_nxt  = rd_free;
            has_prev_nxt   = 1'b1;
          end
        end
      end
      S_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_of(split_start_r);
        ram_wdata = {1'b1, split_size_r};
        state_nxt = S_RESP;
      end
      S_MERGE: begin
        // Entries of absorbed blocks go stale; the walk never reaches them again.
        ram_we = 1'b1;
        if (has_prev_r && prev_free_r) begin
          ram_waddr = idx_of(prev_start_r);
          ram_wdata = {1'b1, prev_merged[SZW-1:0]};
        end else begin
          ram_waddr = idx_of(hit_start_r);
          ram_wdata = {1'b1, merged[SZW-1:0]};
        end
        res_status_nxt = ST_OK;
        res_addr_nxt   = '0;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    req_r         <= req_nxt;
    rel_r         <= rel_nxt;
    cur_r         <= cur_nxt;
    prev_start_r  <= prev_start_nxt;
    prev_size_r   <= prev_size_nxt;
    prev_free_r   <= prev_free_nxt;
    has_prev_r    <= has_prev_nxt;
    hit_start_r   <= hit_start_nxt;
    hit_size_r    <= hit_size_nxt;
    has_succ_r    <= has_succ_nxt;
    split_start_r <= split_start_nxt;
    split_size_r  <= split_size_nxt;
    res_status_r  <= res_status_nxt;
    res_addr_r    <= res_addr_nxt;
    out_status_r  <= out_status_nxt;
    out_addr_r    <= out_addr_nxt;
  end

  // A release can only succeed or be flagged as a bad address.
  a_release_no_nofit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && mode_r |-> (res_status_r != ST_NOFIT))
    else $error("release produced a no-fit status");

  // Every failed result carries a zero payload address.
  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_addr_r == '0))
    else $error("failed result with nonzero payload address");

  // The walk cursor always points at a block inside the heap.
  a_cursor_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (cur_r < HEAP))
    else $error("block walk left the heap");

  // After a request transfer the block is busy until its result is queued.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("request taken while another is in flight");

endmodule

>>> hw/rtl/ffha_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Uses no package.
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/ffha_round.sv
// Two-stage unit that rounds a request size up to a multiple of the alignment.
// Division by the alignment is a multiply by a fixed reciprocal. Depends on ffha_pkg.
module ffha_round
  import ffha_pkg::*;
#(
  parameter int unsigned ALIGN_BYTES = 8
) (
  input  logic              clk,
  input  logic [REQ_W-1:0]  req,
  output logic [BYTE_W-1:0] need
);

  // Shift of the reciprocal; large enough that the quotient is exact for any request.
  localparam int unsigned K     = REQ_W + 8;
  localparam int unsigned MW    = K - 1;
  localparam int unsigned XW    = REQ_W + 1;
  localparam int unsigned PW    = XW + MW;
  localparam int unsigned QW    = PW - K;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << K) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));

  logic [XW-1:0]     x;
  logic [PW-1:0]     prod;
  logic [QW-1:0]     q_r;
  logic [BYTE_W-1:0] need_r;

  assign x    = XW'(req) + XW'(ALIGN_BYTES - 1);
  assign prod = PW'(x) * PW'(RECIP);

  always_ff @(posedge clk) begin
    q_r    <= prod[PW-1:K];
    need_r <= BYTE_W'(q_r) * BYTE_W'(ALIGN_BYTES);
  end

  assign need = need_r;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the first-fit heap allocator: directed and random
// allocate/release traffic checked against an in-bench model of the block chain.
// Depends on ffha_pkg and first_fit_heap_allocator only.
module testbench
  import ffha_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Heap geometry, matching the defaults of the block under test.
  localparam int unsigned HEAP_BYTES   = 1024;
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned BLOCK_SLOTS  = HEAP_BYTES / HEADER_BYTES + 1;
  localparam int unsigned MAX_PAYLOAD  = HEAP_BYTES - HEADER_BYTES;

  // Random traffic volume; the final stretch runs with no idling on either side.
  localparam int unsigned RANDOM_ITEMS = 1080;
  localparam int unsigned CALM_ITEMS   = 150;
  // Idle time after the last owed result is checked, before the verdict.
  localparam int unsigned DRAIN_CYCLES = 64;

  // Operation codes carried in in_tuser.
  typedef enum bit {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } heap_op_t;

  typedef struct {
    heap_op_t     op;
    logic [15:0]  size;
    logic [9:0]   addr;
  } heap_req_t;

  typedef struct {
    status_t      status;
    logic [9:0]   payload;
  } heap_res_t;

  // One row of the directed plan. Where 'typed' is set, the result column is
  // taken as the expectation; otherwise the heap model supplies it.
  typedef struct {
    heap_op_t     op;
    int unsigned  size;
    int unsigned  addr;
    bit           typed;
    status_t      status;
    int unsigned  payload;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 24;

  // The plan walks through: a zero-size request on a fresh heap, oversize
  // requests, releases of a header, of the last address of the heap, of a free
  // block and of a mid-payload address, a whole-heap allocation, a
  // three-block pattern released so that both neighbor merges happen, an
  // allocation too tight to split, a split that leaves a one-unit block that
  // is then taken exactly, and a request when nothing is free.
  plan_row_t plan [0:PLAN_ROWS-1] = '{
    '{OP_ALLOC,   0,     0,    1'b1, ST_OK,     32},
    '{OP_ALLOC,   65535, 0,    1'b1, ST_NOFIT,  0},
    '{OP_ALLOC,   993,   0,    1'b1, ST_NOFIT,  0},
    '{OP_RELEASE, 0,     0,    1'b1, ST_BADREL, 0},
    '{OP_RELEASE, 0,     1023, 1'b1, ST_BADREL, 0},
    '{OP_RELEASE, 0,     64,   1'b1, ST_BADREL, 0},
    '{OP_RELEASE, 0,     32,   1'b1, ST_OK,     0},
    '{OP_ALLOC,   992,   0,    1'b1, ST_OK,     32},
    '{OP_RELEASE, 0,     32,   1'b1, ST_OK,     0},
    '{OP_ALLOC,   1,     0,    1'b0, ST_OK,     0},
    '{OP_ALLOC,   7,     0,    1'b0, ST_OK,     0},
    '{OP_ALLOC,   16,    0,    1'b0, ST_OK,     0},
    '{OP_RELEASE, 0,     33,   1'b1, ST_BADREL, 0},
    '{OP_RELEASE, 0,     32,   1'b0, ST_OK,     0},
    '{OP_RELEASE, 0,     112,  1'b0, ST_OK,     0},
    '{OP_RELEASE, 0,     72,   1'b0, ST_OK,     0},
    '{OP_ALLOC,   960,   0,    1'b0, ST_OK,     0},
    '{OP_RELEASE, 0,     32,   1'b0, ST_OK,     0},
    '{OP_ALLOC,   952,   0,    1'b0, ST_OK,     0},
    '{OP_ALLOC,   8,     0,    1'b0, ST_OK,     0},
    '{OP_ALLOC,   0,     0,    1'b0, ST_OK,     0},
    '{OP_RELEASE, 0,     32,   1'b0, ST_OK,     0},
    '{OP_RELEASE, 0,     1016, 1'b0, ST_OK,     0},
    '{OP_ALLOC,   40000, 0,    1'b1, ST_NOFIT,  0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  first_fit_heap_allocator #(
    .HEAP_BYTES   (HEAP_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Heap model: address-ordered block records, kept in step with the block.
  int unsigned blk_start [BLOCK_SLOTS];
  int unsigned blk_size  [BLOCK_SLOTS];
  bit          blk_free  [BLOCK_SLOTS];
  int unsigned blk_count;

  // Results that the block still owes, oldest first.
  heap_res_t   owed_results [$];
  int unsigned failures;

  // Idling controls shared by the request and result sides.
  bit idle_on;
  bit calm;

  function automatic void heap_reset();
    foreach (blk_start[i]) begin
      blk_start[i] = 0;
      blk_size[i]  = 0;
      blk_free[i]  = 1'b0;
    end
    blk_size[0] = MAX_PAYLOAD;
    blk_free[0] = 1'b1;
    blk_count   = 1;
  endfunction

  function automatic void heap_drop(int unsigned idx);
    for (int unsigned k = idx; k + 1 < blk_count; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_size[k]  = blk_size[k+1];
      blk_free[k]  = blk_free[k+1];
    end
    blk_count--;
  endfunction

  // Takes the first free block that fits and splits off the tail when the
  // tail can hold a header plus one alignment unit.
  function automatic heap_res_t heap_alloc(int unsigned bytes);
    heap_res_t   res;
    int unsigned need;
    need = ((bytes + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    res.status  = ST_NOFIT;
    res.payload = '0;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= need) begin
        if (blk_size[i] >= need + HEADER_BYTES + ALIGN_BYTES && blk_count < BLOCK_SLOTS) begin
          for (int unsigned k = blk_count; k > i + 1; k--) begin
            blk_start[k] = blk_start[k-1];
            blk_size[k]  = blk_size[k-1];
            blk_free[k]  = blk_free[k-1];
          end
          blk_start[i+1] = blk_start[i] + HEADER_BYTES + need;
          blk_size[i+1]  = blk_size[i] - need - HEADER_BYTES;
          blk_free[i+1]  = 1'b1;
          blk_size[i]    = need;
          blk_count++;
        end
        blk_free[i] = 1'b0;
        res.status  = ST_OK;
        res.payload = 10'(blk_start[i] + HEADER_BYTES);
        return res;
      end
    end
    return res;
  endfunction

  // Frees the allocated block whose payload starts at the address and merges
  // it with a free successor first, then with a free predecessor.
  function automatic heap_res_t heap_release(int unsigned addr);
    heap_res_t   res;
    int unsigned hit;
    bit          found;
    res.status  = ST_BADREL;
    res.payload = '0;
    found = 1'b0;
    hit   = 0;
    for (int unsigned i = 0; i < blk_count && !found; i++) begin
      if (!blk_free[i] && blk_start[i] + HEADER_BYTES == addr) begin
        found = 1'b1;
        hit   = i;
      end
    end
    if (!found) return res;
    blk_free[hit] = 1'b1;
    if (hit + 1 < blk_count && blk_free[hit+1]) begin
      blk_size[hit] += blk_size[hit+1] + HEADER_BYTES;
      heap_drop(hit + 1);
    end
    if (hit > 0 && blk_free[hit-1]) begin
      blk_size[hit-1] += blk_size[hit] + HEADER_BYTES;
      heap_drop(hit);
    end
    res.status = ST_OK;
    return res;
  endfunction

  function automatic heap_res_t heap_apply(heap_req_t req);
    if (req.op == OP_ALLOC) return heap_alloc(req.size);
    return heap_release(req.addr);
  endfunction

  // Random traffic is mostly well-formed: allocations of mostly small sizes
  // and releases of blocks that are live right now. The rest is noise:
  // arbitrary release addresses, addresses inside a live payload, and
  // requests of any 16-bit size.
  function automatic heap_req_t pick_random_request();
    heap_req_t   req;
    int unsigned live [$];
    int unsigned roll;
    int unsigned alloc_odds;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (!blk_free[i]) live.push_back(blk_start[i] + HEADER_BYTES);
    end
    req.op   = OP_ALLOC;
    req.size = '0;
    req.addr = '0;
    // Lean toward allocation while few blocks are live so the heap fills up,
    // and toward release once it is crowded.
    alloc_odds = (live.size() < 3) ? 75 : (live.size() > 10) ? 35 : 50;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      req.op   = OP_RELEASE;
      req.addr = 10'($urandom_range(0, 1023));
    end else if (roll < 11 && live.size() != 0) begin
      req.op   = OP_RELEASE;
      req.addr = 10'(live[$urandom_range(0, live.size() - 1)] + $urandom_range(1, 8));
    end else if (roll < 11 + alloc_odds || live.size() == 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      req.size = 16'($urandom_range(0, 64));
      else if (roll < 90) req.size = 16'($urandom_range(65, 300));
      else if (roll < 97) req.size = 16'($urandom_range(301, MAX_PAYLOAD));
      else                req.size = 16'($urandom);
    end else begin
      req.op   = OP_RELEASE;
      req.addr = 10'(live[$urandom_range(0, live.size() - 1)]);
    end
    return req;
  endfunction

  // Drives one request, holding it until the transfer, then books the
  // expected result. A pinned result from the directed plan replaces the
  // model's answer, though the model still advances its state.
  task automatic send_request(heap_req_t req, bit pinned, heap_res_t pinned_res);
    heap_res_t modeled;
    if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.op;
    in_tdata  <= {6'd0, req.addr, req.size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    modeled = heap_apply(req);
    owed_results.push_back(pinned ? pinned_res : modeled);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request side: reset, the directed plan, then random traffic.
  initial begin
    heap_req_t req;
    heap_res_t pinned_res;
    failures  = 0;
    idle_on   = 1'b1;
    calm      = 1'b0;
    heap_reset();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      req.op             = plan[r].op;
      req.size           = 16'(plan[r].size);
      req.addr           = 10'(plan[r].addr);
      pinned_res.status  = plan[r].status;
      pinned_res.payload = 10'(plan[r].payload);
      send_request(req, plan[r].typed, pinned_res);
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // Idling is switched on and off in stretches so that some runs of
      // traffic go back to back.
      if (n % 64 == 0) idle_on = ($urandom_range(0, 2) != 0);
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      send_request(pick_random_request(), 1'b0, pinned_res);
    end
    in_tvalid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && owed_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: the receiver stalls in bursts while idling is on, outside the calm stretch.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Every result transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    heap_res_t owed;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_results.size() == 0) begin
        $error("result transfer with nothing owed: status %0d payload_address %0d",
               out_tuser, out_tdata[9:0]);
        failures++;
      end else begin
        owed = owed_results.pop_front();
        if (out_tuser !== owed.status) begin
          $error("status: expected %0d, actual %0d", owed.status, out_tuser);
          failures++;
        end
        if (out_tdata[9:0] !== owed.payload) begin
          $error("payload_address: expected %0d, actual %0d", owed.payload, out_tdata[9:0]);
          failures++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
